@@ hw/rtl/uvs_pkg.sv @@
`timescale 1ns / 1ps
package uvs_pkg;

    localparam int MaxDivisionsDefault   = 255;
    localparam int TrigIterationsDefault = 16;
    localparam int AtanEntries           = 24;

    localparam logic [31:0] PiQ30      = 32'd3373259426;
    localparam logic [31:0] CordicGain = 32'd652032874;
    localparam logic [7:0]  CountReset = 8'd20;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic REG_STACK  = 1'b0;
    localparam logic REG_SECTOR = 1'b1;

    typedef struct packed {
        logic [7:0] stack_index;
        logic [7:0] sector_index;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [15:0]        index_a;
        logic [15:0]        index_b;
        logic [15:0]        index_c;
        logic               last;
    } out_beat_t;

    // state handed from cell to cell down the chain
    typedef struct packed {
        logic               vld;
        logic               rej;
        logic [7:0]         i;
        logic [7:0]         j;
        logic [9:0]         s;
        logic [9:0]         t;
        logic [41:0]        num_a;
        logic [41:0]        num_b;
        logic [31:0]        quo_a;
        logic [31:0]        quo_b;
        logic               zero_a;
        logic               zero_b;
        logic [1:0]         quad_a;
        logic [1:0]         quad_b;
        logic signed [33:0] xa;
        logic signed [33:0] ya;
        logic signed [33:0] za;
        logic signed [33:0] xb;
        logic signed [33:0] yb;
        logic signed [33:0] zb;
    } cell_t;

    function automatic logic [31:0] atan_q30(input int k);
        logic [31:0] v;
        begin
            case (k)
                0: v = 32'd843314857;
                1: v = 32'd497837829;
                2: v = 32'd263043837;
                3: v = 32'd133525159;
                4: v = 32'd67021687;
                5: v = 32'd33543516;
                6: v = 32'd16775851;
                7: v = 32'd8388437;
                8: v = 32'd4194283;
                9: v = 32'd2097149;
                default: v = (k < AtanEntries) ? (32'd1 << (30 - k)) : 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hw/rtl/uv_sphere_mesh_generator.sv @@
`timescale 1ns / 1ps
// uv sphere tessellation
// in channel: in_valid/in_stall/in_data carry one grid point (stack, sector)
// per beat. out channel: out_valid/out_stall/out_data carry result beats:
// a vertex beat, then up to two triangle beats; a grid point outside the
// configured counts gives one reject beat. last marks the final beat of a point.
// cfg_we/cfg_index/cfg_data write stack_count (0) and sector_count (1); write
// only while idle. counts of 0 act as 1, above MAX_DIVISIONS as MAX_DIVISIONS.
// the chain is 32 divide cells, 2 radian-scale stages, TRIG_ITERATIONS cordic
// cells and 2 product/round stages. the pace of grid points is set by the result
// beats each one makes on the single output port; the chain advances as a whole
// and pauses while the emitter still holds beats of the previous point.
// reset clears all valid flags and sets both counts to 20. a stall on the
// out channel freezes the emitter and, once it is busy, the whole chain.
module uv_sphere_mesh_generator
#(
    parameter int MAX_DIVISIONS   = uvs_pkg::MaxDivisionsDefault,
    parameter int TRIG_ITERATIONS = uvs_pkg::TrigIterationsDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  uvs_pkg::in_beat_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output uvs_pkg::out_beat_t out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data
);
    import uvs_pkg::*;

    localparam int NDiv = 32;
    localparam int NCor = TRIG_ITERATIONS;
    localparam logic [9:0] MaxDiv = 10'(MAX_DIVISIONS);

    logic [7:0] stack_count_reg;
    logic [7:0] sector_count_reg;
    logic       adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg  <= CountReset;
            sector_count_reg <= CountReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STACK)
                stack_count_reg <= cfg_data;
            else
                sector_count_reg <= cfg_data;
        end
    end

    function automatic logic [9:0] eff(input logic [7:0] r);
        logic [9:0] v;
        begin
            v = (r == 8'd0) ? 10'd1 : {2'b00, r};
            if (v > MaxDiv)
                v = MaxDiv;
            return v;
        end
    endfunction

    // head of the chain: load the divide operands
    cell_t head;
    always_comb
    begin
        head       = '0;
        head.vld   = in_valid;
        head.i     = in_data.stack_index;
        head.j     = in_data.sector_index;
        head.s     = eff(stack_count_reg);
        head.t     = eff(sector_count_reg);
        head.rej   = ({2'b00, in_data.stack_index} > head.s) ||
                     ({2'b00, in_data.sector_index} > head.t);
        // i as the starting remainder over 2S gives floor(i*2^31/S) in 32 steps
        head.num_a = {2'b00, in_data.stack_index, 32'd0};
        // j over T gives floor(j*2^32/T); j = T is a full turn and wraps to zero
        head.num_b = ({2'b00, in_data.sector_index} == head.t) ? 42'd0 :
                     {2'b00, in_data.sector_index, 32'd0};
        head.quo_a = '0;
        head.quo_b = '0;
    end

    cell_t dv [0:NDiv];
    assign dv[0] = head;

    genvar g;
    generate
        for (g = 0; g < NDiv; g++)
        begin : g_div
            uvs_div_cell u_div (
                .clk (clk), .rst_n (rst_n), .adv (adv),
                .din (dv[g]), .dout (dv[g+1])
            );
        end
    endgenerate

    // radian scale stage 1: multiply 30-bit residual by pi in two halves
    cell_t       r1_next;
    cell_t       r1_reg;
    logic [31:0] tha;
    logic [31:0] phb;
    logic [46:0] pa_lo_reg, pa_hi_reg, pb_lo_reg, pb_hi_reg;
    always_comb
    begin
        tha = dv[NDiv].quo_a;
        phb = dv[NDiv].quo_b;
        r1_next        = dv[NDiv];
        r1_next.quad_a = tha[31:30];
        r1_next.quad_b = phb[31:30];
        r1_next.zero_a = (tha[29:0] == 30'd0);
        r1_next.zero_b = (phb[29:0] == 30'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r1_reg <= '0;
        else if (adv)
            r1_reg <= r1_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_lo_reg <= 47'(tha[14:0] * PiQ30);
            pa_hi_reg <= 47'(tha[29:15] * PiQ30);
            pb_lo_reg <= 47'(phb[14:0] * PiQ30);
            pb_hi_reg <= 47'(phb[29:15] * PiQ30);
        end
    end

    // stage 2: sum partial products, start cordic
    cell_t r2_next;
    cell_t r2_reg;
    logic [62:0] za_full, zb_full;
    always_comb
    begin
        za_full = {pa_hi_reg, 15'd0} + 63'(pa_lo_reg);
        zb_full = {pb_hi_reg, 15'd0} + 63'(pb_lo_reg);
        r2_next    = r1_reg;
        r2_next.za = $signed({2'b00, za_full[62:31]});
        r2_next.zb = $signed({2'b00, zb_full[62:31]});
        r2_next.xa = $signed({2'b00, CordicGain});
        r2_next.xb = $signed({2'b00, CordicGain});
        r2_next.ya = '0;
        r2_next.yb = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r2_reg <= '0;
        else if (adv)
            r2_reg <= r2_next;
    end

    cell_t cr [0:NCor];
    assign cr[0] = r2_reg;
    generate
        for (g = 0; g < NCor; g++)
        begin : g_cor
            uvs_cordic_cell #(.Step(g)) u_cor (
                .clk (clk), .rst_n (rst_n), .adv (adv),
                .din (cr[g]), .dout (cr[g+1])
            );
        end
    endgenerate

    // quadrant fix-up
    cell_t              cf;
    logic signed [33:0] ct, st, cp, sp, x0a, y0a, x0b, y0b;
    always_comb
    begin
        cf  = cr[NCor];
        x0a = cf.zero_a ? 34'sd1073741824 : cf.xa;
        y0a = cf.zero_a ? 34'sd0 : cf.ya;
        x0b = cf.zero_b ? 34'sd1073741824 : cf.xb;
        y0b = cf.zero_b ? 34'sd0 : cf.yb;
        case (cf.quad_a)
            2'd0:    begin ct = x0a;  st = y0a;  end
            2'd1:    begin ct = -y0a; st = x0a;  end
            2'd2:    begin ct = -x0a; st = -y0a; end
            default: begin ct = y0a;  st = -x0a; end
        endcase
        case (cf.quad_b)
            2'd0:    begin cp = x0b;  sp = y0b;  end
            2'd1:    begin cp = -y0b; sp = x0b;  end
            2'd2:    begin cp = -x0b; sp = -y0b; end
            default: begin cp = y0b;  sp = -x0b; end
        endcase
    end

    // product stage: 34x34 split in halves over the registered sum
    cell_t              m_reg;
    logic signed [33:0] ct_reg;
    logic signed [50:0] xl_reg, xh_reg, yl_reg, yh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_reg <= '0;
        else if (adv)
            m_reg <= cf;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ct_reg <= ct;
            xl_reg <= 51'(st * $signed({1'b0, cp[16:0]}));
            xh_reg <= 51'(st * $signed(cp[33:17]));
            yl_reg <= 51'(st * $signed({1'b0, sp[16:0]}));
            yh_reg <= 51'(st * $signed(sp[33:17]));
        end
    end

    function automatic logic signed [15:0] rnd_sat(input logic signed [67:0] v,
                                                   input int sh);
        logic signed [67:0] r;
        begin
            r = (v + (68'sd1 <<< (sh - 1))) >>> sh;
            if (r > 68'sd16384)
                r = 68'sd16384;
            else if (r < -68'sd16384)
                r = -68'sd16384;
            return r[15:0];
        end
    endfunction

    // sum the product halves; round texture coordinates from the angle quotients
    logic signed [67:0] px, py;
    logic [16:0] tu, tv;
    always_comb
    begin
        px = (68'(xh_reg) <<< 17) + 68'(xl_reg);
        py = (68'(yh_reg) <<< 17) + 68'(yl_reg);
        // quo_a is floor(i*2^31/S): round to q1.16 from 15 extra bits
        tu = 17'((33'(m_reg.quo_a) + 33'd16384) >> 15);
        // quo_b is floor(j*2^32/T): round to q1.16 from 16 extra bits
        tv = 17'((33'(m_reg.quo_b) + 33'd32768) >> 16);
        if (m_reg.i == m_reg.s[7:0] && m_reg.s[9:8] == 2'b00)
            tu = 17'd65536;
        if (m_reg.j == m_reg.t[7:0] && m_reg.t[9:8] == 2'b00)
            tv = 17'd65536;
    end

    // emitter: holds up to three beats of one grid point
    out_beat_t b_reg [0:2];
    logic [1:0] cnt_reg;
    logic [1:0] ptr_reg;
    logic       busy;
    logic       take;
    out_beat_t  vb, t1, t2;
    logic       has1, has2;
    logic [15:0] k1, k2;

    assign busy = (cnt_reg != 2'd0);
    assign take = busy && !out_stall;
    // chain advances unless the emitter is busy and stays so
    assign adv  = !busy || (take && (ptr_reg + 2'd1 == cnt_reg));
    assign in_stall = !adv;

    always_comb
    begin
        k1   = 16'(m_reg.i * (m_reg.t + 10'd1) + 16'(m_reg.j));
        k2   = 16'(k1 + 16'(m_reg.t) + 16'd1);
        has1 = ({2'b00, m_reg.i} < m_reg.s) && ({2'b00, m_reg.j} < m_reg.t) &&
               (m_reg.i != 8'd0);
        has2 = ({2'b00, m_reg.i} < m_reg.s) && ({2'b00, m_reg.j} < m_reg.t) &&
               ({2'b00, m_reg.i} != m_reg.s - 10'd1);
        vb = '0;
        vb.kind  = KIND_VERTEX;
        vb.pos_x = rnd_sat(px, 46);
        vb.pos_y = rnd_sat(py, 46);
        vb.pos_z = rnd_sat(68'(ct_reg), 16);
        vb.tex_u = tu;
        vb.tex_v = tv;
        vb.last  = !has1 && !has2;
        t1 = '0;
        t1.kind = KIND_TRI;
        t1.index_a = k1;
        t1.index_b = k2;
        t1.index_c = 16'(k1 + 16'd1);
        t1.last = !has2;
        t2 = '0;
        t2.kind = KIND_TRI;
        t2.index_a = 16'(k1 + 16'd1);
        t2.index_b = k2;
        t2.index_c = 16'(k2 + 16'd1);
        t2.last = 1'b1;
        if (m_reg.rej)
        begin
            vb = '0;
            vb.kind = KIND_REJECT;
            vb.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end
        else if (adv)
        begin
            ptr_reg <= 2'd0;
            if (m_reg.vld)
                cnt_reg <= m_reg.rej ? 2'd1 : 2'd1 + 2'(has1) + 2'(has2);
            else
                cnt_reg <= 2'd0;
        end
        else if (take)
            ptr_reg <= ptr_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg[0] <= vb;
            b_reg[1] <= has1 ? t1 : t2;
            b_reg[2] <= t2;
        end
    end

    assign out_valid = busy;
    assign out_data  = b_reg[ptr_reg];

endmodule

@@ hw/rtl/uvs_div_cell.sv @@
`timescale 1ns / 1ps
// one restoring-division bit for both angle quotients
module uvs_div_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  uvs_pkg::cell_t din,
    output uvs_pkg::cell_t dout
);
    import uvs_pkg::*;

    cell_t       nxt;
    logic [42:0] ra;
    logic [42:0] rb;
    logic [42:0] da;
    logic [42:0] db;

    always_comb
    begin
        nxt = din;
        // remainder in top bits; low bits shift in zeros
        ra  = {din.num_a, 1'b0};
        rb  = {din.num_b, 1'b0};
        // theta divides by 2S, phi by T
        da  = {din.s, 1'b0, 32'd0};
        db  = {1'b0, din.t, 32'd0};
        nxt.num_a = ra[41:0];
        nxt.num_b = rb[41:0];
        nxt.quo_a = {din.quo_a[30:0], 1'b0};
        nxt.quo_b = {din.quo_b[30:0], 1'b0};
        if (ra >= da)
        begin
            nxt.num_a  = 42'(ra - da);
            nxt.quo_a[0] = 1'b1;
        end
        if (rb >= db)
        begin
            nxt.num_b  = 42'(rb - db);
            nxt.quo_b[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout <= '0;
        else if (adv)
            dout <= nxt;
    end
endmodule

@@ hw/rtl/uvs_cordic_cell.sv @@
`timescale 1ns / 1ps
// one cordic rotation step on both angles
module uvs_cordic_cell
#(
    parameter int Step = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  uvs_pkg::cell_t din,
    output uvs_pkg::cell_t dout
);
    import uvs_pkg::*;

    localparam logic signed [33:0] Atan = $signed({2'b00, atan_q30(Step)});

    cell_t nxt;

    always_comb
    begin
        nxt = din;
        if (din.za >= 0)
        begin
            nxt.xa = din.xa - (din.ya >>> Step);
            nxt.ya = din.ya + (din.xa >>> Step);
            nxt.za = din.za - Atan;
        end
        else
        begin
            nxt.xa = din.xa + (din.ya >>> Step);
            nxt.ya = din.ya - (din.xa >>> Step);
            nxt.za = din.za + Atan;
        end
        if (din.zb >= 0)
        begin
            nxt.xb = din.xb - (din.yb >>> Step);
            nxt.yb = din.yb + (din.xb >>> Step);
            nxt.zb = din.zb - Atan;
        end
        else
        begin
            nxt.xb = din.xb + (din.yb >>> Step);
            nxt.yb = din.yb - (din.xb >>> Step);
            nxt.zb = din.zb + Atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout <= '0;
        else if (adv)
            dout <= nxt;
    end
endmodule

@@ hw/rtl/uvs_checker.sv @@
`timescale 1ns / 1ps
module uvs_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input uvs_pkg::out_beat_t out_data
);
    import uvs_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled beat changed");
    a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_REJECT |-> out_data.last)
        else $error("reject beat without last");
    a_tri_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_TRI |->
        out_data.pos_x == 16'sd0 && out_data.tex_u == 17'd0)
        else $error("triangle beat carries vertex data");
    a_no_tri_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.kind == KIND_TRI && !out_data.last
        |=> out_valid && out_data.kind == KIND_TRI)
        else $error("triangle pair broken");
endmodule

bind uv_sphere_mesh_generator uvs_checker u_uvs_checker (
    .clk (clk), .rst_n (rst_n), .out_valid (out_valid),
    .out_stall (out_stall), .out_data (out_data)
);

@@ sim/uv_sphere_mesh_checker.sv @@
`timescale 1ns / 1ps
module uv_sphere_mesh_checker
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  uvs_pkg::in_beat_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  uvs_pkg::out_beat_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data,
    output int        errors,
    output int        pending
);
    import uvs_pkg::*;

    localparam int MaxDiv   = MaxDivisionsDefault;
    localparam int TrigIter = TrigIterationsDefault;

    logic [7:0] stack_reg;
    logic [7:0] sector_reg;
    out_beat_t  expected_beats[$];

    function automatic longint atan_entry(input int k);
        case (k)
            0: return 843314857;
            1: return 497837829;
            2: return 263043837;
            3: return 133525159;
            4: return 67021687;
            5: return 33543516;
            6: return 16775851;
            7: return 8388437;
            8: return 4194283;
            9: return 2097149;
            default: return longint'(1) << (30 - k);
        endcase
    endfunction

    // arithmetic shift on signed longint floors
    function automatic void turn_trig(input logic [31:0] turn, output longint c,
                                      output longint s);
        longint x, y, z, dx, dy;
        logic [63:0] r;
        r = {34'd0, turn[29:0]};
        if (r == 0)
        begin
            x = longint'(1) << 30;
            y = 0;
        end
        else
        begin
            z = longint'((r * 64'd3373259426) >> 31);
            x = 652032874;
            y = 0;
            for (int k = 0; k < TrigIter; k++)
            begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_entry(k);
                end
                else
                begin
                    x += dx; y -= dy; z += atan_entry(k);
                end
            end
        end
        case (turn[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [15:0] to_q14(input longint v, input int sh);
        longint q;
        q = (v + (longint'(1) << (sh - 1))) >>> sh;
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q[15:0];
    endfunction

    function automatic int eff_count(input logic [7:0] r);
        if (r == 0) return 1;
        if (r > MaxDiv) return MaxDiv;
        return r;
    endfunction

    task automatic predict_grid_point(input in_beat_t g);
        longint unsigned st_cnt, sc_cnt, i, j, k1, k2;
        logic [31:0] th, ph;
        longint ct, sn, cp, sp;
        out_beat_t b;
        out_beat_t beats[$];
        st_cnt = eff_count(stack_reg);
        sc_cnt = eff_count(sector_reg);
        i = g.stack_index;
        j = g.sector_index;
        b = '0;
        if (i > st_cnt || j > sc_cnt)
        begin
            b.kind = KIND_REJECT;
            b.last = 1'b1;
            expected_beats.push_back(b);
            return;
        end
        th = 32'((i << 31) / st_cnt);
        ph = 32'((j << 32) / sc_cnt);
        turn_trig(th, ct, sn);
        turn_trig(ph, cp, sp);
        b.kind  = KIND_VERTEX;
        b.pos_x = to_q14(sn * cp, 46);
        b.pos_y = to_q14(sn * sp, 46);
        b.pos_z = to_q14(ct, 16);
        b.tex_u = 17'((i * 131072 + st_cnt) / (2 * st_cnt));
        b.tex_v = 17'((j * 131072 + sc_cnt) / (2 * sc_cnt));
        beats.push_back(b);
        if (i < st_cnt && j < sc_cnt)
        begin
            k1 = i * (sc_cnt + 1) + j;
            k2 = k1 + sc_cnt + 1;
            if (i != 0)
            begin
                b = '0;
                b.kind = KIND_TRI;
                b.index_a = k1[15:0];
                b.index_b = k2[15:0];
                b.index_c = 16'(k1 + 1);
                beats.push_back(b);
            end
            if (i != st_cnt - 1)
            begin
                b = '0;
                b.kind = KIND_TRI;
                b.index_a = 16'(k1 + 1);
                b.index_b = k2[15:0];
                b.index_c = 16'(k2 + 1);
                beats.push_back(b);
            end
        end
        beats[beats.size() - 1].last = 1'b1;
        foreach (beats[n]) expected_beats.push_back(beats[n]);
    endtask

    task automatic compare_field(input string name, input longint exp_v,
                                 input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t e;
        if (!rst_n)
        begin
            stack_reg  <= CountReset;
            sector_reg <= CountReset;
            errors = 0;
            expected_beats.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_STACK) stack_reg <= cfg_data;
                else sector_reg <= cfg_data;
            end
            if (in_valid && !in_stall) predict_grid_point(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat %h", out_data);
                    errors++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    compare_field("kind", e.kind, out_data.kind);
                    compare_field("pos_x", e.pos_x, out_data.pos_x);
                    compare_field("pos_y", e.pos_y, out_data.pos_y);
                    compare_field("pos_z", e.pos_z, out_data.pos_z);
                    compare_field("tex_u", e.tex_u, out_data.tex_u);
                    compare_field("tex_v", e.tex_v, out_data.tex_v);
                    compare_field("index_a", e.index_a, out_data.index_a);
                    compare_field("index_b", e.index_b, out_data.index_b);
                    compare_field("index_c", e.index_c, out_data.index_c);
                    compare_field("last", e.last, out_data.last);
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

@@ sim/uv_sphere_mesh_generator_tb.sv @@
`timescale 1ns / 1ps
module uv_sphere_mesh_generator_tb;
    import uvs_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 80;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;
    logic      cfg_we = 1'b0;
    logic      cfg_index = REG_STACK;
    logic [7:0] cfg_data = '0;

    int errors;
    int pending;
    int send_idle_pct = 0;   // chance per cycle that the sender holds off
    int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int quiet_cycles = 0;

    // grid dimensions as last written, used to aim stimulus
    int stacks = 20;
    int sectors = 20;

    always #6 clk = ~clk;

    uv_sphere_mesh_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    uv_sphere_mesh_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // receiver: one random stall decision per edge
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // watchdog: cycles with no beat accepted on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // one grid point beat; valid stays high into the next beat unless the sender idles
    task automatic send_point(input int i, input int j);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.stack_index  <= i[7:0];
        in_data.sector_index <= j[7:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // idle gap between phases
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_counts(input int s, input int t);
        cfg_we <= 1'b1; cfg_index <= REG_STACK; cfg_data <= s[7:0];
        @(posedge clk);
        cfg_index <= REG_SECTOR; cfg_data <= t[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        stacks  = (s == 0) ? 1 : s;
        sectors = (t == 0) ? 1 : t;
    endtask

    // mostly in-range grid points with a few out-of-range ones
    task automatic random_points(input int n);
        int i, j;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) == 0)
            begin
                i = $urandom_range(255);
                j = $urandom_range(255);
            end
            else
            begin
                i = $urandom_range(stacks);
                j = $urandom_range(sectors);
            end
            send_point(i, j);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed at reset counts: poles, equator, seams, out of range
        send_point(0, 0);
        send_point(20, 20);
        send_point(19, 5);
        send_point(10, 10);
        send_point(1, 19);
        send_point(5, 20);
        send_point(20, 3);
        send_point(21, 0);
        send_point(0, 21);
        send_point(255, 255);
        send_point(170, 85);
        wait_drained();

        // zero registers act as one: single stack, both triangles skipped
        write_counts(0, 0);
        send_point(0, 0);
        send_point(1, 1);
        send_point(0, 1);
        send_point(2, 0);
        wait_drained();

        // largest counts
        write_counts(255, 255);
        send_point(255, 255);
        send_point(254, 254);
        send_point(127, 64);
        send_point(0, 254);
        wait_drained();

        write_counts(3, 7);
        random_points(15);
        wait_drained();

        send_idle_pct = 84;
        write_counts(1, 255);
        random_points(20);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 84;
        write_counts(200, 13);
        random_points(25);
        wait_drained();

        send_idle_pct = 15;
        recv_stall_pct = 15;
        write_counts(20, 20);
        random_points(25);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_counts(9, 4);
        random_points(20);
        wait_drained();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ uv_sphere_mesh_generator.f @@
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_div_cell.sv
hw/rtl/uvs_cordic_cell.sv
hw/rtl/uv_sphere_mesh_generator.sv
hw/rtl/uvs_checker.sv
sim/uv_sphere_mesh_checker.sv
sim/uv_sphere_mesh_generator_tb.sv
